// ===== hdl/upc_pkg.sv =====
package upc_pkg;

  localparam int RANK_W = 11;
  localparam int COUNT_W = 11;
  localparam int RANK_COUNT_RESET = 1024;

  typedef struct packed {
    logic clr_init;
    logic clr_step;
    logic load;
    logic q_step;
    logic judge;
    logic up_step;
    logic emit;
  } upc_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic q_last;
    logic store_ok;
    logic up_last;
    logic out_free;
  } upc_stat_t;

endpackage

// ===== hdl/undominated_point_counter_core.sv =====
// each input transfer is loaded, queried one tree level per cycle, judged, then written
//   back up to the root; its result goes to the output register once that register is free.
//   The single read port of the node memory serves the query, then the update.
// Items whose second rank lies outside the active range skip the update. A new input is
// taken only after the last result is loaded. Reset and each config write start a clearing
//   pass over all nodes during which no input transfer is taken; count returns to zero
module undominated_point_counter_core #(
  parameter int MAX_RANKS = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [10:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // second_rank [10:0], third_rank [21:11]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // undominated [0], undominated_total [11:1]
);
  import upc_pkg::*;

  upc_cmd_t           cmd;
  upc_stat_t          stat;
  logic               out_flag;
  logic [COUNT_W-1:0] out_total;

  upc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  upc_datapath #(
    .MAX_RANKS (MAX_RANKS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .second_rank_i     (s_axis_tdata[10:0]),
    .third_rank_i      (s_axis_tdata[21:11]),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .out_valid_o       (m_axis_tvalid),
    .out_ready_i       (m_axis_tready),
    .out_undominated_o (out_flag),
    .out_total_o       (out_total)
  );

  assign m_axis_tdata = {4'b0000, out_total, out_flag};

endmodule

// ===== hdl/upc_ctrl.sv =====
module upc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  upc_pkg::upc_stat_t stat_i,
  output upc_pkg::upc_cmd_t  cmd_o
);
  import upc_pkg::*;

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_QUERY  = 6'b000100,
    ST_JUDGE  = 6'b001000,
    ST_UPDATE = 6'b010000,
    ST_FINISH = 6'b100000
  } upc_state_e;

  upc_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE) && !cfg_we_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_QUERY;
        end
      end
      ST_QUERY: begin
        cmd_o.q_step = 1'b1;
        if (stat_i.q_last) state_d = ST_JUDGE;
      end
      ST_JUDGE: begin
        cmd_o.judge = 1'b1;
        state_d     = stat_i.store_ok ? ST_UPDATE : ST_FINISH;
      end
      ST_UPDATE: begin
        cmd_o.up_step = 1'b1;
        if (stat_i.up_last) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
    if (cfg_we_i) begin
      cmd_o          = '0;
      cmd_o.clr_init = 1'b1;
      state_d        = ST_CLEAR;
    end
  end

endmodule

// ===== hdl/upc_datapath.sv =====
module upc_datapath #(
  parameter int MAX_RANKS = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [upc_pkg::RANK_W-1:0]   cfg_wdata_i,
  input  logic [upc_pkg::RANK_W-1:0]   second_rank_i,
  input  logic [upc_pkg::RANK_W-1:0]   third_rank_i,
  input  upc_pkg::upc_cmd_t            cmd_i,
  output upc_pkg::upc_stat_t           stat_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         out_undominated_o,
  output logic [upc_pkg::COUNT_W-1:0]  out_total_o
);
  import upc_pkg::*;

  localparam int LVL = (MAX_RANKS > 1) ? $clog2(MAX_RANKS) : 1;
  localparam int AW = LVL + 1;
  localparam int VW = ($clog2(MAX_RANKS + 2) > RANK_W) ? $clog2(MAX_RANKS + 2) : RANK_W;
  localparam int CW = $clog2(LVL + 1);
  localparam int LEAVES = 2 ** LVL;
  localparam int RcReset = (RANK_COUNT_RESET > MAX_RANKS) ? MAX_RANKS : RANK_COUNT_RESET;
  localparam logic [VW-1:0] Sentinel = VW'(MAX_RANKS + 1);
  localparam logic [COUNT_W-1:0] CountMax = '1;

  logic [VW-1:0]      tree_q [2**AW];
  logic [VW-1:0]      rdata_q;
  logic [AW-1:0]      raddr;
  logic               we;
  logic [AW-1:0]      waddr;
  logic [VW-1:0]      wdata;

  logic [RANK_W-1:0]  rc_q;
  logic [COUNT_W-1:0] count_q;
  logic [AW-1:0]      clr_addr_q;
  logic               take_q;
  logic               out_valid_q;

  logic [AW-1:0]      bsh_q;
  logic [AW-1:0]      qaddr_q;
  logic [CW-1:0]      cnt_q;
  logic [VW-1:0]      m_q;
  logic [RANK_W-1:0]  val_q;
  logic [AW-1:0]      leaf_q;
  logic               store_ok_q;
  logic [AW-1:0]      cur_q;
  logic [VW-1:0]      cur_val_q;
  logic               flag_q;
  logic               out_flag_q;
  logic [COUNT_W-1:0] out_total_q;

  logic [RANK_W-1:0]  bound;
  logic [RANK_W-1:0]  pos_m1;
  logic               q_bit;
  logic [VW-1:0]      m_now;
  logic [AW-1:0]      parent;
  logic [VW-1:0]      up_min;
  logic               out_free;

  assign bound  = (second_rank_i < rc_q) ? second_rank_i : rc_q;
  assign pos_m1 = second_rank_i - RANK_W'(1);
  assign q_bit  = bsh_q[AW-1];
  assign m_now  = (take_q && (rdata_q < m_q)) ? rdata_q : m_q;
  assign parent = cur_q >> 1;
  assign up_min = (rdata_q < cur_val_q) ? rdata_q : cur_val_q;
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    raddr = qaddr_q;
    we    = 1'b0;
    waddr = clr_addr_q;
    wdata = Sentinel;
    if (cmd_i.clr_step) begin
      we = 1'b1;
    end
    if (cmd_i.judge) begin
      raddr = leaf_q ^ AW'(1);
      we    = store_ok_q;
      waddr = leaf_q;
      wdata = VW'(val_q);
    end
    if (cmd_i.up_step) begin
      raddr = parent ^ AW'(1);
      we    = 1'b1;
      waddr = parent;
      wdata = up_min;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) tree_q[waddr] <= wdata;
    rdata_q <= tree_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rc_q        <= RANK_W'(RcReset);
      count_q     <= '0;
      clr_addr_q  <= '0;
      take_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      take_q <= cmd_i.q_step & q_bit;
      if (cfg_we_i) begin
        rc_q <= (int'(cfg_wdata_i) > MAX_RANKS) ? RANK_W'(MAX_RANKS) : cfg_wdata_i;
      end
      if (cmd_i.clr_init) begin
        count_q    <= '0;
        clr_addr_q <= '0;
      end else begin
        if (cmd_i.clr_step) clr_addr_q <= clr_addr_q + AW'(1);
        if (cmd_i.judge && (m_now > VW'(val_q)) && (count_q != CountMax)) begin
          count_q <= count_q + COUNT_W'(1);
        end
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      bsh_q      <= AW'(bound);
      qaddr_q    <= AW'(1);
      cnt_q      <= '0;
      val_q      <= third_rank_i;
      leaf_q     <= AW'(LEAVES) | AW'(pos_m1);
      store_ok_q <= (second_rank_i != '0) && (second_rank_i <= rc_q);
    end else if (cmd_i.q_step) begin
      bsh_q   <= bsh_q << 1;
      qaddr_q <= (qaddr_q | AW'(q_bit)) << 1;
      cnt_q   <= cnt_q + CW'(1);
    end
    if (cmd_i.load) begin
      m_q <= Sentinel;
    end else begin
      m_q <= m_now;
    end
    if (cmd_i.judge) begin
      flag_q    <= m_now > VW'(val_q);
      cur_q     <= leaf_q;
      cur_val_q <= VW'(val_q);
    end else if (cmd_i.up_step) begin
      cur_q     <= parent;
      cur_val_q <= up_min;
    end
    if (cmd_i.emit) begin
      out_flag_q  <= flag_q;
      out_total_q <= count_q;
    end
  end

  assign stat_o.clr_last = (clr_addr_q == '1);
  assign stat_o.q_last   = (cnt_q == CW'(LVL));
  assign stat_o.store_ok = store_ok_q;
  assign stat_o.up_last  = (parent == AW'(1));
  assign stat_o.out_free = out_free;

  assign out_valid_o       = out_valid_q;
  assign out_undominated_o = out_flag_q;
  assign out_total_o       = out_total_q;

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> out_free)
    else $error("result loaded over an untaken result");

  a_count_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg_we_i |=> count_q >= $past(count_q))
    else $error("running count went down without a config write");

  a_count_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.judge && !cfg_we_i) |=> (count_q == $past(count_q)) || flag_q)
    else $error("count moved on a dominated point");

  a_update_node: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.up_step |-> parent != '0)
    else $error("update walked above the root");

endmodule

// ===== verif/undominated_point_counter_core_test.sv =====
`timescale 1ns / 100ps

module undominated_point_counter_core_test;
  import upc_pkg::*;

  localparam int MAX_RANKS = 1024;
  localparam logic [RANK_W-1:0] RANK_SENTINEL = RANK_W'(MAX_RANKS + 1);
  localparam logic [COUNT_W-1:0] COUNT_SAT = '1;
  localparam int DRAIN_CYCLES = 30;
  localparam int HOLD_CYCLES = 3000;

  typedef struct packed {
    logic [RANK_W-1:0] third_rank;
    logic [RANK_W-1:0] second_rank;
  } point_t;

  typedef struct packed {
    logic [COUNT_W-1:0] undominated_total;
    logic               undominated;
  } verdict_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [10:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;  // second_rank [10:0], third_rank [21:11]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;       // undominated [0], undominated_total [11:1]

  point_t   points_to_send[$];
  verdict_t verdicts_due[$];

  logic [RANK_W-1:0]  stored_rank [1:MAX_RANKS];
  logic [COUNT_W-1:0] undom_count;
  int                 active_ranks;

  int  send_idle_pct = 0;
  int  stall_pct = 0;
  bit  hold_go = 1'b0;
  int  hold_count = 0;
  int  mismatches = 0;

  undominated_point_counter_core #(
    .MAX_RANKS(MAX_RANKS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  task automatic clear_run_state(input logic [10:0] size);
    active_ranks = (size > MAX_RANKS) ? MAX_RANKS : size;
    for (int i = 1; i <= MAX_RANKS; i++) stored_rank[i] = RANK_SENTINEL;
    undom_count = '0;
  endtask

  // prefix minimum over positions 1..second_rank, capped at the active size, decides the flag, then the store
  function automatic verdict_t dominance_predict(point_t p);
    logic [RANK_W-1:0] lowest;
    int                bound;
    verdict_t          v;
    lowest = RANK_SENTINEL;
    bound = (p.second_rank > active_ranks) ? active_ranks : p.second_rank;
    for (int i = 1; i <= bound; i++)
      if (stored_rank[i] < lowest) lowest = stored_rank[i];
    v.undominated = (lowest > p.third_rank);
    if (v.undominated && undom_count != COUNT_SAT) undom_count = undom_count + 1'b1;
    if (p.second_rank >= 1 && p.second_rank <= active_ranks)
      stored_rank[p.second_rank] = p.third_rank;
    v.undominated_total = undom_count;
    return v;
  endfunction

  // sender
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready)
      verdicts_due.push_back(dominance_predict(s_axis_tdata[21:0]));
    if (!s_axis_tvalid || s_axis_tready) begin
      if (rst_ni && points_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        s_axis_tdata  <= {2'b00, points_to_send.pop_front()};
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver and checker
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      if (verdicts_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected transfer, expected none, actual %h", $time, m_axis_tdata);
      end else begin
        verdict_t want;
        want = verdicts_due.pop_front();
        if (m_axis_tdata[0] !== want.undominated) begin
          mismatches++;
          $display("%0t: undominated expected %b actual %b", $time, want.undominated,
                   m_axis_tdata[0]);
        end
        if (m_axis_tdata[11:1] !== want.undominated_total) begin
          mismatches++;
          $display("%0t: undominated_total expected %0d actual %0d", $time,
                   want.undominated_total, m_axis_tdata[11:1]);
        end
      end
    end
    if (hold_go && hold_count < HOLD_CYCLES) begin
      m_axis_tready <= 1'b0;
      hold_count    <= hold_count + 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic queue_point(input int second, input int third);
    point_t p;
    p.second_rank = RANK_W'(second);
    p.third_rank  = RANK_W'(third);
    points_to_send.push_back(p);
  endtask

  task automatic wait_drained();
    while (points_to_send.size() != 0 || s_axis_tvalid || verdicts_due.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_phase(input int size, input int items, input int s_idle,
                           input int r_stall, input bit squeeze);
    int roll;
    int second;
    int third;
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= RANK_W'(size);
    clear_run_state(RANK_W'(size));
    @(posedge clk_i);
    cfg_we_i      <= 1'b0;
    send_idle_pct = s_idle;
    stall_pct     = r_stall;
    if (squeeze) hold_go = 1'b1;
    for (int k = 0; k < items; k++) begin
      roll = $urandom_range(99);
      if (roll < 80) begin
        second = (active_ranks == 0) ? $urandom_range(2047) : $urandom_range(active_ranks, 1);
        if ($urandom_range(3) == 0) third = $urandom_range(active_ranks / 8 + 1, 1);
        else third = $urandom_range(MAX_RANKS, 1);
      end else begin
        second = $urandom_range(2047);
        third  = $urandom_range(2047);
      end
      queue_point(second, third);
    end
    wait_drained();
  endtask

  initial begin
    clear_run_state(RANK_W'(RANK_COUNT_RESET));
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed corners at the reset size
    queue_point(0, 5);
    queue_point(1024, 1024);
    queue_point(1, 2047);
    queue_point(2, 1025);
    queue_point(1024, 1);
    queue_point(2047, 0);
    queue_point(1025, 0);
    queue_point(1, 0);
    queue_point(1, 0);
    queue_point(512, 3);
    queue_point(511, 2);
    queue_point(0, 0);
    queue_point(0, 2047);
    queue_point(1536, 1536);
    queue_point(2047, 2047);
    queue_point(1023, 1025);
    queue_point(1, 1);
    queue_point(1365, 682);
    queue_point(682, 1365);
    queue_point(1024, 0);
    wait_drained();

    run_phase(1024, 400, 62, 0, 1'b0);
    run_phase(1, 200, 0, 62, 1'b0);
    run_phase(2047, 400, 31, 31, 1'b1);
    run_phase(7, 300, 0, 0, 1'b0);
    run_phase(2, 200, 62, 0, 1'b0);
    run_phase(300, 300, 31, 31, 1'b0);
    // empty tree: no store lands and every query sees the sentinel
    run_phase(0, 200, 0, 0, 1'b0);

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
